/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted (active low).
`define RNP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define RNP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* rtl/rnp_pkg.sv */
// Shared types and constants for the repeating n-gram period detector.
package rnp_pkg;

  localparam int MAX_PERIOD_DEF = 16;
  localparam int COUNT_BITS_DEF = 24;

  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 5;
  localparam int PERIOD_W = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  // Per-transaction control broadcast to every cell.
  typedef struct packed {
    logic shift;    // a byte was accepted
    logic restart;  // that byte closes the page
  } cell_ctl_t;

  // History byte handed from cell to cell.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;  // byte belongs to the current page
  } hist_t;

endpackage

/* rtl/rnp_cell.sv */
// One candidate-period cell: history tap, match flag and end-of-page test.
module rnp_cell #(
  parameter int PER        = 1,
  parameter int COUNT_BITS = rnp_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rnp_pkg::cell_ctl_t            ctl,
  input  logic [rnp_pkg::BYTE_W-1:0]    cur_byte,
  input  rnp_pkg::hist_t                hist_in,
  input  logic [COUNT_BITS-1:0]         page_len,
  input  logic [rnp_pkg::LIMIT_W-1:0]   limit,
  output rnp_pkg::hist_t                hist_out,
  output logic                          qualify
);
  import rnp_pkg::*;

  logic [BYTE_W-1:0] hist_data_r;
  logic              hist_valid_r, hist_valid_nxt;
  logic              match_r, match_nxt;
  logic              hit, match_now;

  // hist holds the byte PER positions back; equal to it means periodic so far
  assign hit       = hist_valid_r && (hist_data_r != cur_byte);
  assign match_now = match_r && !hit;

  assign qualify = match_now
                && (page_len > COUNT_BITS'(2 * PER))
                && (int'(limit) > PER);

  assign hist_out.data  = hist_data_r;
  assign hist_out.valid = hist_valid_r;

  always_comb begin
    hist_valid_nxt = hist_valid_r;
    match_nxt      = match_r;
    if (ctl.shift) begin
      hist_valid_nxt = ctl.restart ? 1'b0 : hist_in.valid;
      match_nxt      = ctl.restart ? 1'b1 : match_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r <= 1'b0;
      match_r      <= 1'b1;
    end else begin
      hist_valid_r <= hist_valid_nxt;
      match_r      <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hist_data_r <= hist_in.data;
    end
  end

endmodule

/* rtl/rnp_pick.sv */
// Result stages: captures qualify flags, picks the smallest period, holds output.
module rnp_pick #(
  parameter int MAX_PERIOD = rnp_pkg::MAX_PERIOD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic [MAX_PERIOD-2:0]          qual,
  output logic                           can_take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rnp_pkg::PERIOD_W-1:0]   out_period
);
  import rnp_pkg::*;

  localparam int NC = MAX_PERIOD - 1;
  localparam int FW = $clog2(MAX_PERIOD);

  logic          s1_v_r, s1_v_nxt;
  logic [NC-1:0] s1_q_r;
  logic          out_v_r, out_v_nxt;
  logic [PERIOD_W-1:0] period_r;

  logic s2_free;
  logic [FW-1:0]          found;
  logic [FW+PERIOD_W-1:0] found_ext;

  assign s2_free  = !out_v_r || out_ready;
  assign can_take = !s1_v_r || s2_free;

  // smallest set index wins
  always_comb begin
    found = '0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (s1_q_r[i]) begin
        found = FW'(i + 1);
      end
    end
  end

  assign found_ext = {{PERIOD_W{1'b0}}, found};

  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (take) begin
      s1_v_nxt = 1'b1;
    end else if (s2_free) begin
      s1_v_nxt = 1'b0;
    end
    if (s2_free) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_q_r <= qual;
    end
    if (s2_free) begin
      period_r <= found_ext[PERIOD_W-1:0];
    end
  end

  assign out_valid  = out_v_r;
  assign out_period = period_r;

endmodule

/* rtl/repeating_ngram_period.sv */
// Top level: smallest repeating period of a page, one byte per cycle.
// Throughput: one byte transaction per cycle; in_ready drops only while both result
// stages hold a period and out_ready is low.
// out_valid rises after the last byte's flags pass the capture and pick stages.
// A row of MAX_PERIOD-1 cells shifts the recent bytes along, all compared in parallel.
// Reset (rst_n low, synchronous): page restarts, no result pending, period_limit = 10.
module repeating_ngram_period #(
  parameter int MAX_PERIOD = rnp_pkg::MAX_PERIOD_DEF,
  parameter int COUNT_BITS = rnp_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input byte channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rnp_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_last_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rnp_pkg::PERIOD_W-1:0]  out_period,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [rnp_pkg::LIMIT_W-1:0]   cfg_period_limit
);
  import rnp_pkg::*;

  localparam int NC = MAX_PERIOD - 1;  // candidate periods 1 .. MAX_PERIOD-1

  logic                  accept;
  cell_ctl_t             ctl;
  logic [COUNT_BITS-1:0] count_r, count_nxt, len_now;
  logic [LIMIT_W-1:0]    limit_r, limit_nxt;
  logic                  can_take;
  logic [NC-1:0]         qual;
  hist_t                 links [0:NC];

  // A byte is taken whenever the first result stage can absorb a possible
  // end-of-page result; it falls only when both result stages hold a period
  // and out_ready is low.
  assign in_ready    = can_take;
  assign accept      = in_valid && in_ready;
  assign ctl.shift   = accept;
  assign ctl.restart = accept && in_last_byte;

  // Page length including the current byte, saturating at all ones.
  assign len_now = (&count_r) ? count_r : count_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    limit_nxt = limit_r;
    if (accept) begin
      count_nxt = in_last_byte ? '0 : len_now;
    end
    if (cfg_wr_en) begin
      limit_nxt = cfg_period_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      count_r <= count_nxt;
      limit_r <= limit_nxt;
    end
  end

  // Head of the chain: the current byte becomes the one-back history.
  assign links[0].data  = in_data_byte;
  assign links[0].valid = 1'b1;

  // Cell k tests period k+1. Matching the byte p back at every step is the
  // same as matching the page's opening bytes at offset mod p, since a cell
  // stays set only while every earlier byte matched too.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    rnp_cell #(
      .PER        (k + 1),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cur_byte (in_data_byte),
      .hist_in  (links[k]),
      .page_len (len_now),
      .limit    (limit_r),
      .hist_out (links[k+1]),
      .qualify  (qual[k])
    );
  end

  // Qualify flags are captured on the last byte, then priority encoded.
  rnp_pick #(
    .MAX_PERIOD (MAX_PERIOD)
  ) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (ctl.restart),
    .qual       (qual),
    .can_take   (can_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_period (out_period)
  );

endmodule

/* rtl/repeating_ngram_period_chk.sv */
// Port-level checker for the period detector, bound to the top level.
`include "assert_macros.svh"

module repeating_ngram_period_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_period
);

  // no result pending right after reset
  `RNP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // a rise of out_valid traces back to an earlier last-byte transaction
  `RNP_ASSERT(a_result_origin, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte, 2))

  // a stalled result holds
  `RNP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_period))

endmodule

bind repeating_ngram_period repeating_ngram_period_chk u_chk (.*);

/* verif/period_checker.sv */
`timescale 1ns / 1ps
// Period checker: predicts each page's period and compares it with the result channel.
module period_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [rnp_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_last_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [rnp_pkg::PERIOD_W-1:0] out_period,
  input  logic                         cfg_wr_en,
  input  logic [rnp_pkg::LIMIT_W-1:0]  cfg_period_limit,
  output int                           mismatches,
  output int                           pending
);
  import rnp_pkg::*;

  localparam int CANDS = MAX_PERIOD_DEF - 1;
  localparam logic [COUNT_BITS_DEF-1:0] LEN_SAT = '1;

  // Predictor state for the page in progress
  logic [BYTE_W-1:0]         head_bytes [CANDS];
  logic [3:0]                phase_cnt  [CANDS];
  logic [CANDS-1:0]          matching;
  logic [COUNT_BITS_DEF-1:0] page_len;
  logic [LIMIT_W-1:0]        limit_reg;

  // Periods owed by the block, oldest first
  logic [PERIOD_W-1:0]       periods_due [$];

  task automatic start_page();
    for (int k = 0; k < CANDS; k++) phase_cnt[k] = '0;
    matching = '1;
    page_len = '0;
  endtask

  task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
    int                  eff_limit;
    logic [PERIOD_W-1:0] found;
    if (page_len < CANDS) head_bytes[page_len[3:0]] = b;
    for (int k = 0; k < CANDS; k++) begin
      if (page_len >= k + 1 && head_bytes[phase_cnt[k]] != b) matching[k] = 1'b0;
      phase_cnt[k] = (int'(phase_cnt[k]) + 1 >= k + 1) ? 4'd0 : phase_cnt[k] + 4'd1;
    end
    if (page_len != LEN_SAT) page_len = page_len + 1'b1;
    if (last) begin
      eff_limit = (limit_reg > MAX_PERIOD_DEF) ? MAX_PERIOD_DEF : int'(limit_reg);
      found = '0;
      // walk down so the smallest qualifying period is the one left
      for (int k = CANDS - 1; k >= 0; k--) begin
        if (k + 1 < eff_limit && matching[k] && 2 * (k + 1) < page_len)
          found = PERIOD_W'(k + 1);
      end
      periods_due = {periods_due, found};
      start_page();
    end
  endtask

  always @(posedge clk) begin
    logic [PERIOD_W-1:0] want;
    if (!rst_n) begin
      limit_reg = LIMIT_RESET;
      start_page();
      periods_due.delete();
    end else begin
      if (in_valid && in_ready) scan_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) begin
        if (periods_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result, period %0d", $time, out_period);
        end else begin
          want = periods_due.pop_front();
          if (out_period !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: period mismatch, expected %0d, actual %0d",
                       $time, want, out_period);
          end
        end
      end
      if (cfg_wr_en) limit_reg = cfg_period_limit;
    end
    pending = periods_due.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Testbench top: drives page bytes and period-limit writes into the block, gives the verdict.
module testbench;
  import rnp_pkg::*;

  localparam int CANDS       = MAX_PERIOD_DEF - 1;
  localparam int CYCLE_LIMIT = 400000;  // many times the slowest legal run
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off to back the block up
  localparam int PHASE_BYTES = 125;     // minimum bytes per random phase

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_data_byte;
  logic                in_last_byte;
  logic                out_valid;
  logic                out_ready;
  logic [PERIOD_W-1:0] out_period;
  logic                cfg_wr_en;
  logic [LIMIT_W-1:0]  cfg_period_limit;

  int   mismatches;
  int   pending;
  int   send_idle_pct  = 0;   // read only by the stimulus process
  int   recv_stall_pct = 0;   // changed with nonblocking writes, read by the receiver
  int   bytes_sent     = 0;
  int   cycle_cnt      = 0;
  logic start_hold     = 1'b0;
  logic hold_off       = 1'b0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  repeating_ngram_period u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_period       (out_period),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_period_limit (cfg_period_limit)
  );

  period_checker u_period_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_period       (out_period),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_period_limit (cfg_period_limit),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  // One byte transaction. Entered and left right after a falling edge; valid is
  // only raised after any idle gap and then held with a fixed payload until the
  // transaction completes at a rising edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Bias toward the byte extremes so runs of equal bytes show up often.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // One random page. Most pages repeat a random pattern of a random period, so
  // candidates survive to the end; some carry one flipped bit somewhere, and the
  // rest are noise drawn partly from the pattern.
  task automatic send_page(input int max_len);
    int                len;
    int                per;
    int                bad;
    logic              periodic;
    logic [BYTE_W-1:0] pat [CANDS];
    logic [BYTE_W-1:0] b;
    len      = $urandom_range(max_len, 1);
    per      = $urandom_range(CANDS, 1);
    periodic = ($urandom_range(99) < 75);
    bad      = ($urandom_range(99) < 25) ? $urandom_range(len - 1) : -1;
    for (int k = 0; k < CANDS; k++) pat[k] = pick_byte();
    for (int k = 0; k < len; k++) begin
      if (periodic) b = pat[k % per];
      else          b = $urandom_range(1) ? pick_byte() : pat[$urandom_range(per - 1)];
      if (k == bad) b = b ^ (8'h01 << $urandom_range(7));
      send_byte(b, k == len - 1);
    end
  endtask

  // Wait until every owed period has come back, plus the pipeline depth, so the
  // block is idle for a limit write or the end of the run.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_wr_en        <= 1'b1;
    cfg_period_limit <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: ready decided at each falling edge, forced low during a hold-off.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold-off timer: once asked, keep the receiver stalled while the sender keeps
  // pushing short pages.
  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus
  initial begin
    int                 phase_start;
    logic [LIMIT_W-1:0] limits [8];
    limits = '{5'd16, 5'd0, 5'd1, 5'd2, 5'd31, 5'd17, 5'd15, 5'd10};

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_data_byte     <= '0;
    in_last_byte     <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_period_limit <= LIMIT_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pages at the reset limit, no idling.
    // single-byte page: no candidate can qualify
    send_byte(8'hFF, 1'b1);
    // two equal bytes: period 1 matches but 2*1 is not below the length
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
    // three equal bytes: period 1
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
    // period 2 over five bytes
    send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0); send_byte(8'h01, 1'b1);
    // period 2 over exactly two periods: length too short, result 0
    send_byte(8'hA5, 1'b0); send_byte(8'h5A, 1'b0); send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    // alternating extremes broken on the final byte
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b1);

    // Random phases: each one gets its own limit and idle pattern. The limits
    // cover zero, one, the top of the candidate range and values above it.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_limit((ph == 7) ? LIMIT_W'($urandom_range(31)) : limits[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 48; end
        default: begin send_idle_pct = 36; recv_stall_pct <= 36; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES)
        send_page(($urandom_range(7) == 0) ? 100 : 36);

      // Back-pressure burst: short pages while the receiver holds off, so
      // results pile up and the block stops taking bytes.
      if (ph == 0) begin
        start_hold <= 1'b1;
        repeat (40) send_page(3);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
